FILE: hw/rtl/lr_pkg.sv
package lr_pkg;

	// coordinate and datapath widths
	localparam int COORD_BITS     = 12;
	localparam int OUT_COORD_BITS = 12;
	localparam int ERR_BITS       = COORD_BITS + 3;
	localparam int CNT_BITS       = COORD_BITS + 1;
	localparam int WIDTH_BITS     = 13;
	localparam int PROD_BITS      = COORD_BITS + WIDTH_BITS;
	localparam int OFFSET_BITS    = 26;
	localparam int COLOR_BITS     = 32;

	// request modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(1024);

	typedef logic [COORD_BITS-1:0] coord_t;

	// pixel from the walker, before address generation
	typedef struct packed {
		logic                  valid;
		coord_t                x;
		coord_t                y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	// finished result
	typedef struct packed {
		logic                      valid;
		logic [OUT_COORD_BITS-1:0] x;
		logic [OUT_COORD_BITS-1:0] y;
		logic [OFFSET_BITS-1:0]    offset;
		logic [COLOR_BITS-1:0]     color;
		logic                      last;
	} result_t;

	// one unit step along an axis, wrapping
	function automatic coord_t step_coord(input coord_t v, input logic neg);
		step_coord = neg ? v - coord_t'(1) : v + coord_t'(1);
	endfunction

endpackage

FILE: hw/rtl/lr_front.sv
module lr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                mode,
	input  logic [11:0]                         start_x,
	input  logic [11:0]                         start_y,
	input  logic [11:0]                         end_x,
	input  logic [11:0]                         end_y,
	input  logic [lr_pkg::COLOR_BITS-1:0]       pixel_color,
	output lr_pkg::pixel_t                      pix
);
	import lr_pkg::*;

	coord_t                       cur_x_q, cur_y_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic [CNT_BITS-1:0]          left_q;
	coord_t                       major_q, minor_q;
	logic                         ymaj_q, neg_x_q, neg_y_q, busy_q;
	logic [COLOR_BITS-1:0]        color_q;

	coord_t                       bx, by, ex, ey, adx, ady, maj, mnr;
	logic                         nx_neg, ny_neg, ymaj;
	logic signed [ERR_BITS-1:0]   e_sub, e_next;
	logic                         minor_take;
	coord_t                       xs, ys, nx, ny;
	logic [CNT_BITS-1:0]          left_next;

	// line setup: deltas, directions and major axis
	always_comb begin
		bx     = coord_t'(start_x);
		by     = coord_t'(start_y);
		ex     = coord_t'(end_x);
		ey     = coord_t'(end_y);
		nx_neg = ex < bx;
		ny_neg = ey < by;
		adx    = nx_neg ? bx - ex : ex - bx;
		ady    = ny_neg ? by - ey : ey - by;
		ymaj   = adx < ady;
		maj    = ymaj ? ady : adx;
		mnr    = ymaj ? adx : ady;
	end

	// one walk step: error update and axis moves
	always_comb begin
		e_sub      = err_q - $signed(ERR_BITS'({minor_q, 1'b0}));
		minor_take = e_sub[ERR_BITS-1] || (e_sub == '0);
		e_next     = minor_take ? e_sub + $signed(ERR_BITS'({major_q, 1'b0})) : e_sub;
		xs         = step_coord(cur_x_q, neg_x_q);
		ys         = step_coord(cur_y_q, neg_y_q);
		nx         = (ymaj_q && !minor_take) ? cur_x_q : xs;
		ny         = (!ymaj_q && !minor_take) ? cur_y_q : ys;
		left_next  = left_q - CNT_BITS'(1);
	end

	// classify the request into the emitted pixel
	always_comb begin
		pix = '0;
		if (mode == MODE_START) begin
			pix.valid = 1'b1;
			pix.x     = bx;
			pix.y     = by;
			pix.color = pixel_color;
			pix.last  = (maj == '0);
		end else if (busy_q) begin
			pix.valid = 1'b1;
			pix.x     = nx;
			pix.y     = ny;
			pix.color = color_q;
			pix.last  = (left_next == '0);
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			err_q   <= '0;
			left_q  <= '0;
			major_q <= '0;
			minor_q <= '0;
			ymaj_q  <= 1'b0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			color_q <= '0;
			busy_q  <= 1'b0;
		end else if (accept) begin
			if (mode == MODE_START) begin
				cur_x_q <= bx;
				cur_y_q <= by;
				err_q   <= $signed(ERR_BITS'(maj));
				left_q  <= CNT_BITS'(maj);
				major_q <= maj;
				minor_q <= mnr;
				ymaj_q  <= ymaj;
				neg_x_q <= nx_neg;
				neg_y_q <= ny_neg;
				color_q <= pixel_color;
				busy_q  <= (maj != '0);
			end else if (busy_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				err_q   <= e_next;
				left_q  <= left_next;
				busy_q  <= (left_next != '0);
			end
		end
	end

endmodule

FILE: hw/rtl/lr_pix_fifo.sv
module lr_pix_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  lr_pkg::pixel_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output lr_pkg::pixel_t rd_data,
	output logic           empty
);
	import lr_pkg::*;

	pixel_t     mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	assign full    = (count_q == 3'd4);
	assign empty   = (count_q == 3'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(wr_en) - 3'(rd_en);
		end
	end

endmodule

FILE: hw/rtl/lr_back.sv
module lr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lr_pkg::WIDTH_BITS-1:0]  row_width,
	input  lr_pkg::pixel_t                 head,
	input  logic                           head_empty,
	output logic                           head_pop,
	input  logic                           pop,
	output lr_pkg::result_t                res,
	output logic                           empty
);
	import lr_pkg::*;

	pixel_t                 pix_s1;
	logic [PROD_BITS-1:0]   prod_s1;
	logic                   valid_s1;
	logic                   s1_ready;

	result_t                buf_q [2];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [1:0]             count_q;
	logic                   buf_full, buf_wr, buf_rd;
	logic [PROD_BITS:0]     addr_sum;
	result_t                res_new;

	assign buf_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign s1_ready = !valid_s1 || !buf_full;
	assign head_pop = !head_empty && s1_ready;
	assign buf_wr   = valid_s1 && !buf_full;
	assign buf_rd   = pop && !empty;
	assign res      = buf_q[rd_ptr_q];

	// row multiply stage
	always_ff @(posedge clk) begin
		if (head_pop) begin
			pix_s1  <= head;
			prod_s1 <= PROD_BITS'(head.y * row_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= head_pop;
		end
	end

	// pixel index plus column, scaled to bytes
	always_comb begin
		addr_sum       = (PROD_BITS+1)'(prod_s1) + (PROD_BITS+1)'(pix_s1.x);
		res_new.valid  = pix_s1.valid;
		res_new.x      = OUT_COORD_BITS'(pix_s1.x);
		res_new.y      = OUT_COORD_BITS'(pix_s1.y);
		res_new.offset = OFFSET_BITS'({addr_sum, 2'b00});
		res_new.color  = pix_s1.color;
		res_new.last   = pix_s1.last;
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (buf_wr) begin
			buf_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (buf_wr) wr_ptr_q <= !wr_ptr_q;
			if (buf_rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(buf_wr) - 2'(buf_rd);
		end
	end

endmodule

FILE: hw/rtl/line_rasterizer_core.sv
// Bresenham line rasterizer for a 4-byte-per-pixel frame buffer. A start request (mode 0)
// loads both endpoints and the color and returns the first pixel; each step request (mode 1)
// returns the next pixel along the major axis, with last set on the final one. A step while
// no line is active returns an all-zero result with pixel_valid low. One request is accepted
// per clock while the 4-entry queue is not full; per pixel the walker does a subtract,
// a compare and a conditional add on the error term. The byte offset 4*(y*row_width + x) is
// formed behind the queue by one multiply stage and one add, and results wait in a 2-entry
// buffer for pop. row_width may be written only while no requests are in flight.
module line_rasterizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [11:0] start_x,
	input  logic [11:0] start_y,
	input  logic [11:0] end_x,
	input  logic [11:0] end_y,
	input  logic [31:0] pixel_color,
	output logic        empty,
	input  logic        pop,
	output logic        pixel_valid,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [25:0] byte_offset,
	output logic [31:0] out_color,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] row_width
);
	import lr_pkg::*;

	logic                  accept;
	logic                  mid_full, mid_empty, mid_pop;
	pixel_t                front_pix, mid_head;
	result_t               res;
	logic [WIDTH_BITS-1:0] row_width_q;

	assign full      = mid_full;
	assign accept    = push && !mid_full;
	assign cfg_ready = 1'b1;

	// row stride register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= row_width;
		end
	end

	lr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_color (pixel_color),
		.pix         (front_pix)
	);

	lr_pix_fifo u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_pix),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_head),
		.empty   (mid_empty)
	);

	lr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_width  (row_width_q),
		.head       (mid_head),
		.head_empty (mid_empty),
		.head_pop   (mid_pop),
		.pop        (pop),
		.res        (res),
		.empty      (empty)
	);

	// result ports
	assign pixel_valid = res.valid;
	assign pixel_x     = res.x;
	assign pixel_y     = res.y;
	assign byte_offset = res.offset;
	assign out_color   = res.color;
	assign last        = res.last;

	// an idle step result carries nothing
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0 &&
			byte_offset == '0 && out_color == '0 && !last))
		else $error("idle step result not all zero");

	// offsets are always pixel aligned
	a_offset_align: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_offset[1:0] == 2'b00))
		else $error("byte offset not pixel aligned");

	// the back end never drains an empty queue
	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("pop from empty internal queue");

	// a request taken into a full queue would be lost
	a_mid_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !mid_full)
		else $error("push into full internal queue");

endmodule
